/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the NDEF record parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication that must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Clocked implication that must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hdl/ndefp_pkg.sv */
// Package with the types, codes and constants of the NDEF record parser.
package ndefp_pkg;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int TNF_W = 3;
  localparam int CLASS_W = 3;
  localparam int ERR_W = 4;
  localparam int PLEN_W = 32;
  localparam int TOTAL_W = 33;
  localparam int FLAGS_W = 5;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_SINGLE_RECORD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;
  localparam logic [PLEN_W-1:0] MAX_PAYLOAD_RESET = 32'd10485760;

  // Bit positions of the header flags inside the five-bit flags field.
  localparam int HF_MB = 4;
  localparam int HF_ME = 3;
  localparam int HF_CF = 2;
  localparam int HF_SR = 1;
  localparam int HF_IL = 0;

  // TNF values with content rules.
  localparam logic [TNF_W-1:0] TNF_VOID = 3'd0;
  localparam logic [TNF_W-1:0] TNF_OPAQUE = 3'd5;
  localparam logic [TNF_W-1:0] TNF_SAME = 3'd6;
  localparam logic [TNF_W-1:0] TNF_RSVD = 3'd7;

  // Saturation limit of the summed chunk payload.
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = 33'h1_0000_0000;

  // Parser phase, one-hot.
  typedef enum logic [7:0] {
    PH_FLAGS   = 8'b0000_0001,
    PH_TLEN    = 8'b0000_0010,
    PH_PLEN    = 8'b0000_0100,
    PH_IDLEN   = 8'b0000_1000,
    PH_TYPE    = 8'b0001_0000,
    PH_ID      = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_STOP    = 8'b1000_0000
  } phase_t;

  // Class tag of each byte.
  typedef enum logic [CLASS_W-1:0] {
    CLS_FLAGS   = 3'd0,
    CLS_TLEN    = 3'd1,
    CLS_PLEN    = 3'd2,
    CLS_IDLEN   = 3'd3,
    CLS_TYPE    = 3'd4,
    CLS_ID      = 3'd5,
    CLS_PAYLOAD = 3'd6,
    CLS_IGNORED = 3'd7
  } byte_class_t;

  // Error codes.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE           = 4'd0,
    ERR_NO_MB          = 4'd1,
    ERR_EXTRA_MB       = 4'd2,
    ERR_IL_IN_CHUNK    = 4'd3,
    ERR_ME_WITH_CF     = 4'd4,
    ERR_WANT_UNCHANGED = 4'd5,
    ERR_BAD_UNCHANGED  = 4'd6,
    ERR_TYPE_IN_CHUNK  = 4'd7,
    ERR_TOO_LARGE      = 4'd8,
    ERR_EMPTY_HAS_DATA = 4'd9,
    ERR_TYPE_IN_UNK    = 4'd10,
    ERR_AFTER_END      = 4'd11
  } err_t;

  // Configuration seen by the parser core.
  typedef struct packed {
    logic              single_record_mode;
    logic [PLEN_W-1:0] max_payload;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              message_start;
  } item_t;

  // One result item.
  typedef struct packed {
    byte_class_t       byte_class;
    logic [BYTE_W-1:0] out_byte;
    logic [TNF_W-1:0]  record_tnf;
    logic              chunk_flag;
    logic              record_end;
    logic              message_done;
    err_t              error_code;
  } result_t;

  // Class tag of the byte taken in a given phase.
  function automatic byte_class_t phase_class(input phase_t ph);
    byte_class_t c;
    unique case (ph)
      PH_FLAGS:   c = CLS_FLAGS;
      PH_TLEN:    c = CLS_TLEN;
      PH_PLEN:    c = CLS_PLEN;
      PH_IDLEN:   c = CLS_IDLEN;
      PH_TYPE:    c = CLS_TYPE;
      PH_ID:      c = CLS_ID;
      PH_PAYLOAD: c = CLS_PAYLOAD;
      default:    c = CLS_IGNORED;
    endcase
    return c;
  endfunction

endpackage

/* hdl/ndefp_stream_if.sv */
// Stream interfaces for the byte input and the result output of the parser.
interface ndefp_in_if;
  import ndefp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              message_start;

  modport source (output valid, data_byte, message_start, input ready);
  modport sink (input valid, data_byte, message_start, output ready);
endinterface

interface ndefp_out_if;
  import ndefp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] byte_class;
  logic [BYTE_W-1:0]  out_byte;
  logic [TNF_W-1:0]   record_tnf;
  logic               chunk_flag;
  logic               record_end;
  logic               message_done;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, byte_class, out_byte, record_tnf, chunk_flag,
                  record_end, message_done, error_code, input ready);
  modport sink (input valid, byte_class, out_byte, record_tnf, chunk_flag,
                record_end, message_done, error_code, output ready);
endinterface

/* hdl/ndefp_in_stage.sv */
// Input register of the parser: holds one accepted byte item.
module ndefp_in_stage (
  input  logic            clk,
  input  logic            rst,
  ndefp_in_if.sink        bytes,
  input  logic            take,
  output logic            item_valid,
  output ndefp_pkg::item_t item
);
  import ndefp_pkg::*;

  logic vld;

  // Room when empty or when the held item moves on this cycle.
  assign bytes.ready = !vld || take;
  assign item_valid = vld;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (bytes.ready) begin
      vld <= bytes.valid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      item.data_byte <= bytes.data_byte;
      item.message_start <= bytes.message_start;
    end
  end

endmodule

/* hdl/ndefp_core.sv */
// Parser core: record state registers and the per-byte decode logic.
module ndefp_core (
  input  logic               clk,
  input  logic               rst,
  input  ndefp_pkg::cfg_t    cfg,
  input  ndefp_pkg::item_t   item,
  input  logic               fire,
  output ndefp_pkg::result_t result
);
  import ndefp_pkg::*;

  typedef struct packed {
    phase_t             phase;
    logic [FLAGS_W-1:0] header_flags;
    logic [BYTE_W-1:0]  type_left;
    logic [BYTE_W-1:0]  id_left;
    logic [PLEN_W-1:0]  payload_left;
    logic [1:0]         length_byte_count;
    logic [TOTAL_W-1:0] chunk_total;
    logic               in_chunk;
    logic [TNF_W-1:0]   chunk_tnf;
    logic               seen_record;
    err_t               latched_error;
    logic               rec_type_nz;
    logic               rec_id_nz;
  } state_t;

  state_t             st;
  state_t             st_next;
  state_t             st_clear;
  state_t             cur;
  byte_class_t        cls;
  err_t               err;
  logic               rend;
  logic               mdone;
  logic               nb_req;
  logic               end_req;
  logic [BYTE_W-1:0]  b;
  logic               mb;
  logic               me;
  logic               cf;
  logic               il;
  logic [TNF_W-1:0]   tnf;
  logic [PLEN_W-1:0]  pl_new;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sat;

  // State after a clear: expecting a flags byte, everything else zero.
  always_comb begin
    st_clear = '0;
    st_clear.phase = PH_FLAGS;
    st_clear.latched_error = ERR_NONE;
  end

  assign b = item.data_byte;
  assign mb = b[BYTE_W-1-FLAGS_W+1+HF_MB];
  assign me = b[BYTE_W-1-FLAGS_W+1+HF_ME];
  assign cf = b[BYTE_W-1-FLAGS_W+1+HF_CF];
  assign il = b[BYTE_W-1-FLAGS_W+1+HF_IL];
  assign tnf = b[TNF_W-1:0];

  // Payload length shifted in big-endian, and the saturated chunk sum.
  assign pl_new = {cur.payload_left[PLEN_W-BYTE_W-1:0], b};
  assign sum = (TOTAL_W+1)'(cur.chunk_total) + (TOTAL_W+1)'(pl_new);
  assign sat = (sum > (TOTAL_W+1)'(TOTAL_CAP)) ? TOTAL_CAP : sum[TOTAL_W-1:0];

  // Decode of one byte against the current record state.
  always_comb begin
    cur = item.message_start ? st_clear : st;
    st_next = cur;
    cls = CLS_IGNORED;
    err = ERR_NONE;
    rend = 1'b0;
    mdone = 1'b0;
    nb_req = 1'b0;
    end_req = 1'b0;

    if (cur.latched_error != ERR_NONE) begin
      // Bytes after an error are ignored.
    end else if (cur.phase == PH_STOP) begin
      st_next.latched_error = ERR_AFTER_END;
    end else begin
      cls = phase_class(cur.phase);
      unique case (cur.phase)
        PH_FLAGS: begin
          priority if (!mb && !cur.seen_record && !cur.in_chunk &&
                       !cfg.single_record_mode) begin
            err = ERR_NO_MB;
          end else if (mb && cur.seen_record && !cfg.single_record_mode) begin
            err = ERR_EXTRA_MB;
          end else if (cur.in_chunk && il) begin
            err = ERR_IL_IN_CHUNK;
          end else if (cf && me) begin
            err = ERR_ME_WITH_CF;
          end else if (cur.in_chunk && tnf != TNF_SAME) begin
            err = ERR_WANT_UNCHANGED;
          end else if (!cur.in_chunk && tnf == TNF_SAME) begin
            err = ERR_BAD_UNCHANGED;
          end else begin
            st_next.header_flags = b[BYTE_W-1:BYTE_W-FLAGS_W];
            if (!cur.in_chunk) begin
              st_next.chunk_tnf = tnf;
              st_next.chunk_total = '0;
              st_next.rec_type_nz = 1'b0;
              st_next.rec_id_nz = 1'b0;
            end
            st_next.type_left = '0;
            st_next.id_left = '0;
            st_next.payload_left = '0;
            st_next.length_byte_count = '0;
            st_next.phase = PH_TLEN;
          end
        end
        PH_TLEN: begin
          st_next.type_left = b;
          if (cur.in_chunk && b != '0) begin
            err = ERR_TYPE_IN_CHUNK;
          end else begin
            if (b != '0) st_next.rec_type_nz = 1'b1;
            st_next.phase = PH_PLEN;
          end
        end
        PH_PLEN: begin
          st_next.payload_left = pl_new;
          if (cur.header_flags[HF_SR] || cur.length_byte_count == 2'd3) begin
            // Length complete: size checks, then the next section.
            if (pl_new > cfg.max_payload) begin
              err = ERR_TOO_LARGE;
            end else begin
              st_next.chunk_total = sat;
              if (cur.in_chunk && !cur.header_flags[HF_CF] &&
                  sat > TOTAL_W'(cfg.max_payload)) begin
                err = ERR_TOO_LARGE;
              end else if (cur.header_flags[HF_IL]) begin
                st_next.phase = PH_IDLEN;
              end else begin
                nb_req = 1'b1;
              end
            end
          end else begin
            st_next.length_byte_count = 2'(cur.length_byte_count + 2'd1);
          end
        end
        PH_IDLEN: begin
          st_next.id_left = b;
          if (b != '0) st_next.rec_id_nz = 1'b1;
          nb_req = 1'b1;
        end
        PH_TYPE: begin
          st_next.type_left = cur.type_left - 8'd1;
          if (cur.type_left == 8'd1) nb_req = 1'b1;
        end
        PH_ID: begin
          st_next.id_left = cur.id_left - 8'd1;
          if (cur.id_left == 8'd1) nb_req = 1'b1;
        end
        PH_PAYLOAD: begin
          st_next.payload_left = cur.payload_left - 32'd1;
          if (cur.payload_left == 32'd1) end_req = 1'b1;
        end
        default: begin
          // Not reachable for a one-hot phase; the state is kept.
        end
      endcase

      // Choose the next body section, or end the chunk or record.
      if (nb_req) begin
        priority if (st_next.type_left != '0) begin
          st_next.phase = PH_TYPE;
        end else if (st_next.id_left != '0) begin
          st_next.phase = PH_ID;
        end else if (st_next.payload_left != '0) begin
          st_next.phase = PH_PAYLOAD;
        end else begin
          end_req = 1'b1;
        end
      end

      // End of a chunk continues the record; end of a record is validated.
      if (end_req) begin
        if (st_next.header_flags[HF_CF]) begin
          st_next.in_chunk = 1'b1;
          st_next.phase = PH_FLAGS;
        end else begin
          st_next.in_chunk = 1'b0;
          priority if (st_next.chunk_tnf == TNF_VOID &&
                       (st_next.rec_type_nz || st_next.rec_id_nz ||
                        st_next.chunk_total != '0)) begin
            err = ERR_EMPTY_HAS_DATA;
          end else if ((st_next.chunk_tnf == TNF_OPAQUE ||
                        st_next.chunk_tnf == TNF_RSVD) &&
                       st_next.rec_type_nz) begin
            err = ERR_TYPE_IN_UNK;
          end else if (st_next.chunk_tnf == TNF_SAME) begin
            err = ERR_BAD_UNCHANGED;
          end else begin
            st_next.seen_record = 1'b1;
            rend = 1'b1;
            if (cfg.single_record_mode || st_next.header_flags[HF_ME]) begin
              mdone = 1'b1;
              st_next.phase = PH_STOP;
            end else begin
              st_next.phase = PH_FLAGS;
            end
          end
        end
      end

      if (err != ERR_NONE) begin
        st_next.latched_error = err;
      end
    end
  end

  // Result fields for this byte.
  always_comb begin
    result.byte_class = cls;
    result.out_byte = b;
    result.error_code = st_next.latched_error;
    if (cls != CLS_IGNORED && err == ERR_NONE) begin
      result.record_tnf = st_next.chunk_tnf;
      result.chunk_flag = cur.in_chunk || st_next.header_flags[HF_CF];
      result.record_end = rend;
      result.message_done = mdone;
    end else begin
      result.record_tnf = '0;
      result.chunk_flag = 1'b0;
      result.record_end = 1'b0;
      result.message_done = 1'b0;
    end
  end

  // Record state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_clear;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

/* hdl/ndefp_out_stage.sv */
// Result register of the parser: holds one result item for the sink.
module ndefp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               result_valid,
  input  ndefp_pkg::result_t result,
  output logic               advance,
  ndefp_out_if.source        results
);
  import ndefp_pkg::*;

  logic    vld;
  result_t held;

  // The register takes a new result when empty or when its item leaves.
  assign advance = !vld || results.ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (advance) begin
      vld <= result_valid;
    end
  end

  // Result capture.
  always_ff @(posedge clk) begin
    if (advance && result_valid) begin
      held <= result;
    end
  end

  assign results.valid = vld;
  assign results.byte_class = held.byte_class;
  assign results.out_byte = held.out_byte;
  assign results.record_tnf = held.record_tnf;
  assign results.chunk_flag = held.chunk_flag;
  assign results.record_end = held.record_end;
  assign results.message_done = held.message_done;
  assign results.error_code = held.error_code;

endmodule

/* hdl/ndef_record_stream_parser_unit.sv */
// Top level of the NDEF record stream parser.
//
//   Channel   Direction  Handshake        Payload
//   bytes     sink       valid / ready    data_byte, message_start
//   results   source     valid / ready    byte_class, out_byte, record_tnf,
//                                          chunk_flag, record_end,
//                                          message_done, error_code
//   cfg       write      cfg_we           cfg_index, cfg_data
//
// One byte item can be taken each cycle unless the sink stalls. A byte is decoded
// while in the input register; the result register then presents its result item.
// Reset is synchronous: it clears the record state and loads the register defaults.
// When the sink stalls, the input register still takes one more item; after that
// bytes.ready stays low until the sink takes the waiting result.
module ndef_record_stream_parser_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ndefp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ndefp_pkg::CFG_DATA_W-1:0]  cfg_data,
  ndefp_in_if.sink                         bytes,
  ndefp_out_if.source                      results
);
  import ndefp_pkg::*;
  `include "assert_macros.svh"

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    fire;
  result_t result;
  logic    out_vld;
  logic    out_stall;
  logic    out_end;
  logic    out_done;
  logic    out_ok;
  logic    out_ignored;
  logic    out_quiet;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_record_mode <= 1'b0;
      cfg.max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SINGLE_RECORD: cfg.single_record_mode <= cfg_data[0];
        CFG_MAX_PAYLOAD:   cfg.max_payload <= cfg_data[PLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The held byte is decoded when the result register can take its result.
  assign fire = item_valid && advance;

  ndefp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ndefp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .fire   (fire),
    .result (result)
  );

  ndefp_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .result_valid (item_valid),
    .result       (result),
    .advance      (advance),
    .results      (results)
  );

  // Short names for the result port, used by the checks below.
  assign out_vld = results.valid;
  assign out_stall = results.valid && !results.ready;
  assign out_end = results.record_end;
  assign out_done = results.message_done;
  assign out_ok = results.error_code == ERR_NONE;
  assign out_ignored = results.byte_class == CLS_IGNORED;
  assign out_quiet = !results.record_end && !results.chunk_flag && results.record_tnf == '0;

  // Checks on the parser's own logic.
  `ASSERT_SAME(a_done_has_end, clk, rst, out_vld && out_done, out_end, "done without end")
  `ASSERT_SAME(a_end_no_error, clk, rst, out_vld && out_end, out_ok, "record end with error")
  `ASSERT_SAME(a_ignored_quiet, clk, rst, out_vld && out_ignored, out_quiet, "ignored with flags")
  `ASSERT_SAME(a_full_blocks, clk, rst, item_valid && out_stall, !bytes.ready, "taken while full")
  `ASSERT_NEXT(a_fire_fills, clk, rst, fire, out_vld, "decoded item lost")

endmodule

/* tb/ndefp_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts the parser's tagged byte stream and compares it with the output.
module ndefp_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ndefp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ndefp_pkg::CFG_DATA_W-1:0]  cfg_data,
  ndefp_in_if                               byte_mon,
  ndefp_out_if                              tag_mon,
  output int                                bad_tags,
  output int                                tags_waiting
);
  import ndefp_pkg::*;

  // Local copy of the registers.
  logic               cfg_single;
  logic [PLEN_W-1:0]  cfg_max;

  // Parser state as the predictor sees it.
  phase_t             stage;
  logic [FLAGS_W-1:0] hdr;
  logic [BYTE_W-1:0]  type_cnt;
  logic [BYTE_W-1:0]  id_cnt;
  logic [PLEN_W-1:0]  pay_cnt;
  logic [1:0]         len_idx;
  logic [TOTAL_W-1:0] sum_len;
  logic               cont_chunk;
  logic [TNF_W-1:0]   lead_tnf;
  logic               got_record;
  err_t               err_hold;
  logic               has_type;
  logic               has_id;

  // Tags predicted for accepted bytes, oldest first.
  result_t            tag_queue[$];
  result_t            want;
  result_t            got;
  int                 bad_count;
  int                 tag_no;

  function automatic void clear_parser();
    stage      = PH_FLAGS;
    hdr        = '0;
    type_cnt   = '0;
    id_cnt     = '0;
    pay_cnt    = '0;
    len_idx    = '0;
    sum_len    = '0;
    cont_chunk = 1'b0;
    lead_tnf   = '0;
    got_record = 1'b0;
    err_hold   = ERR_NONE;
    has_type   = 1'b0;
    has_id     = 1'b0;
  endfunction

  // Last byte of a chunk or record: continue after a chunk, else apply the content rules.
  function automatic err_t close_record(output logic rend, output logic mdone);
    rend  = 1'b0;
    mdone = 1'b0;
    if (hdr[HF_CF]) begin
      cont_chunk = 1'b1;
      stage      = PH_FLAGS;
      return ERR_NONE;
    end
    cont_chunk = 1'b0;
    if (lead_tnf == TNF_VOID && (has_type || has_id || sum_len != '0))
      return ERR_EMPTY_HAS_DATA;
    if ((lead_tnf == TNF_OPAQUE || lead_tnf == TNF_RSVD) && has_type)
      return ERR_TYPE_IN_UNK;
    if (lead_tnf == TNF_SAME)
      return ERR_BAD_UNCHANGED;
    got_record = 1'b1;
    rend       = 1'b1;
    if (cfg_single || hdr[HF_ME]) begin
      mdone = 1'b1;
      stage = PH_STOP;
    end else begin
      stage = PH_FLAGS;
    end
    return ERR_NONE;
  endfunction

  // Move on to the next nonempty body section, or close the record.
  function automatic err_t pick_body(output logic rend, output logic mdone);
    rend  = 1'b0;
    mdone = 1'b0;
    if (type_cnt != '0) begin
      stage = PH_TYPE;
      return ERR_NONE;
    end
    if (id_cnt != '0) begin
      stage = PH_ID;
      return ERR_NONE;
    end
    if (pay_cnt != '0) begin
      stage = PH_PAYLOAD;
      return ERR_NONE;
    end
    return close_record(rend, mdone);
  endfunction

  // Payload length complete: size checks, then the id length or the body.
  function automatic err_t check_length(output logic rend, output logic mdone);
    rend  = 1'b0;
    mdone = 1'b0;
    if (pay_cnt > cfg_max)
      return ERR_TOO_LARGE;
    sum_len = sum_len + {1'b0, pay_cnt};
    if (sum_len > TOTAL_CAP)
      sum_len = TOTAL_CAP;
    if (cont_chunk && !hdr[HF_CF] && sum_len > {1'b0, cfg_max})
      return ERR_TOO_LARGE;
    if (hdr[HF_IL]) begin
      stage = PH_IDLEN;
      return ERR_NONE;
    end
    return pick_body(rend, mdone);
  endfunction

  // Flags byte: the header rules are tried in the order of their codes.
  function automatic err_t take_header(input logic [BYTE_W-1:0] b);
    logic [FLAGS_W-1:0] f;
    logic [TNF_W-1:0]   t;
    f = b[7:3];
    t = b[2:0];
    if (!f[HF_MB] && !got_record && !cont_chunk && !cfg_single) return ERR_NO_MB;
    if (f[HF_MB] && got_record && !cfg_single) return ERR_EXTRA_MB;
    if (cont_chunk && f[HF_IL]) return ERR_IL_IN_CHUNK;
    if (f[HF_CF] && f[HF_ME]) return ERR_ME_WITH_CF;
    if (cont_chunk && t != TNF_SAME) return ERR_WANT_UNCHANGED;
    if (!cont_chunk && t == TNF_SAME) return ERR_BAD_UNCHANGED;
    hdr = f;
    if (!cont_chunk) begin
      lead_tnf = t;
      sum_len  = '0;
      has_type = 1'b0;
      has_id   = 1'b0;
    end
    type_cnt = '0;
    id_cnt   = '0;
    pay_cnt  = '0;
    len_idx  = '0;
    stage    = PH_TLEN;
    return ERR_NONE;
  endfunction

  // Tag one accepted byte and advance the parser state.
  function automatic result_t classify_byte(input logic [BYTE_W-1:0] b, input logic start);
    result_t r;
    logic    was_chunk;
    logic    rend;
    logic    mdone;
    err_t    err;
    if (start)
      clear_parser();
    was_chunk      = cont_chunk;
    r.byte_class   = CLS_IGNORED;
    r.record_tnf   = '0;
    r.chunk_flag   = 1'b0;
    rend           = 1'b0;
    mdone          = 1'b0;
    err            = ERR_NONE;
    if (err_hold != ERR_NONE) begin
      // An earlier error holds; the byte is only passed through.
    end else if (stage == PH_STOP) begin
      err_hold = ERR_AFTER_END;
    end else begin
      case (stage)
        PH_FLAGS: begin
          r.byte_class = CLS_FLAGS;
          err = take_header(b);
        end
        PH_TLEN: begin
          r.byte_class = CLS_TLEN;
          type_cnt = b;
          if (cont_chunk && b != '0) begin
            err = ERR_TYPE_IN_CHUNK;
          end else begin
            if (b != '0) has_type = 1'b1;
            stage = PH_PLEN;
          end
        end
        PH_PLEN: begin
          r.byte_class = CLS_PLEN;
          pay_cnt = {pay_cnt[PLEN_W-9:0], b};
          if (hdr[HF_SR] || len_idx == 2'd3)
            err = check_length(rend, mdone);
          else
            len_idx = len_idx + 2'd1;
        end
        PH_IDLEN: begin
          r.byte_class = CLS_IDLEN;
          id_cnt = b;
          if (b != '0) has_id = 1'b1;
          err = pick_body(rend, mdone);
        end
        PH_TYPE: begin
          r.byte_class = CLS_TYPE;
          type_cnt = type_cnt - 8'd1;
          if (type_cnt == '0) err = pick_body(rend, mdone);
        end
        PH_ID: begin
          r.byte_class = CLS_ID;
          id_cnt = id_cnt - 8'd1;
          if (id_cnt == '0) err = pick_body(rend, mdone);
        end
        default: begin
          r.byte_class = CLS_PAYLOAD;
          pay_cnt = pay_cnt - 32'd1;
          if (pay_cnt == '0) err = close_record(rend, mdone);
        end
      endcase
      if (err != ERR_NONE) begin
        err_hold = err;
        rend     = 1'b0;
        mdone    = 1'b0;
      end else begin
        r.record_tnf = lead_tnf;
        r.chunk_flag = was_chunk || hdr[HF_CF];
      end
    end
    r.out_byte     = b;
    r.record_end   = rend;
    r.message_done = mdone;
    r.error_code   = err_hold;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_single = 1'b0;
      cfg_max    = MAX_PAYLOAD_RESET;
      clear_parser();
      tag_queue.delete();
      bad_count  = 0;
      tag_no     = 0;
    end else begin
      // Register writes update the local copy.
      if (cfg_we) begin
        if (cfg_index == CFG_SINGLE_RECORD)
          cfg_single = cfg_data[0];
        else if (cfg_index == CFG_MAX_PAYLOAD)
          cfg_max = cfg_data[PLEN_W-1:0];
      end

      // Every accepted byte yields exactly one predicted tag.
      if (byte_mon.valid && byte_mon.ready)
        tag_queue.insert(tag_queue.size(),
                         classify_byte(byte_mon.data_byte, byte_mon.message_start));

      // Compare each delivered tag with the oldest prediction.
      if (tag_mon.valid && tag_mon.ready) begin
        got.byte_class   = byte_class_t'(tag_mon.byte_class);
        got.out_byte     = tag_mon.out_byte;
        got.record_tnf   = tag_mon.record_tnf;
        got.chunk_flag   = tag_mon.chunk_flag;
        got.record_end   = tag_mon.record_end;
        got.message_done = tag_mon.message_done;
        got.error_code   = err_t'(tag_mon.error_code);
        tag_no++;
        if (tag_queue.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("tag %0d: delivered with no byte outstanding", tag_no);
        end else begin
          want = tag_queue.pop_front();
          if (got.byte_class !== want.byte_class || got.out_byte !== want.out_byte ||
              got.record_tnf !== want.record_tnf || got.chunk_flag !== want.chunk_flag ||
              got.record_end !== want.record_end ||
              got.message_done !== want.message_done ||
              got.error_code !== want.error_code) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("tag %0d expected: cls %0d byte %h tnf %0d chk %b end %b done %b err %0d",
                       tag_no, want.byte_class, want.out_byte, want.record_tnf,
                       want.chunk_flag, want.record_end, want.message_done, want.error_code);
              $display("tag %0d actual:   cls %0d byte %h tnf %0d chk %b end %b done %b err %0d",
                       tag_no, got.byte_class, got.out_byte, got.record_tnf,
                       got.chunk_flag, got.record_end, got.message_done, got.error_code);
            end
          end
        end
      end
    end
    bad_tags     <= bad_count;
    tags_waiting <= tag_queue.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the NDEF parser: clock, reset, byte stimulus, output stalls and verdict.
module tb;
  import ndefp_pkg::*;

  localparam int IDLE_LIMIT    = 400;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int PHASE_ITEMS   = 140;
  localparam int SETTLE_CYCLES = 4;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     bad_tags;
  int                     tags_waiting;
  int                     idle_cycles = 0;
  logic                   src_calm = 1'b0;
  logic                   sink_calm = 1'b0;

  // Pending stimulus bytes: bit 8 is message_start, bits 7:0 the data byte.
  logic [8:0]             stim_q[$];

  ndefp_in_if  byte_ch ();
  ndefp_out_if tag_ch ();

  ndef_record_stream_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bytes     (byte_ch),
    .results   (tag_ch)
  );

  ndefp_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_mon     (byte_ch),
    .tag_mon      (tag_ch),
    .bad_tags     (bad_tags),
    .tags_waiting (tags_waiting)
  );

  always #4 clk = ~clk;

  // Watchdog on stretches with no accepted item on either channel.
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if ((byte_ch.valid && byte_ch.ready) || (tag_ch.valid && tag_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result side: a random stall before each item, with calm stretches.
  initial begin
    int stall;
    tag_ch.ready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if ($urandom_range(0, 47) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        tag_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tag_ch.ready <= 1'b1;
      @(posedge clk);
      while (!tag_ch.valid) @(posedge clk);
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic st);
    stim_q.insert(stim_q.size(), {st, b});
  endtask

  // One record or chunk: header bytes, then optionally the type, id and payload bodies.
  task automatic queue_record(input logic mb, me, cf, sr, il, input logic [2:0] tnf,
                              input logic [7:0] tlen, idlen, input logic [31:0] plen,
                              input logic st, body);
    queue_byte({mb, me, cf, sr, il, tnf}, st);
    queue_byte(tlen, 1'b0);
    if (sr) begin
      queue_byte(plen[7:0], 1'b0);
    end else begin
      queue_byte(plen[31:24], 1'b0);
      queue_byte(plen[23:16], 1'b0);
      queue_byte(plen[15:8], 1'b0);
      queue_byte(plen[7:0], 1'b0);
    end
    if (il) queue_byte(idlen, 1'b0);
    if (body) begin
      repeat (tlen) queue_byte(8'($urandom), 1'b0);
      repeat (idlen) queue_byte(8'($urandom), 1'b0);
      repeat (plen) queue_byte(8'($urandom), 1'b0);
    end
  endtask

  // A mostly well-formed message with random content, sometimes broken or followed by noise.
  task automatic queue_message(input logic single);
    int          nrec;
    int          nchunk;
    int          base;
    int          k;
    logic [2:0]  tnf;
    logic        first;
    logic        last;
    logic        lead;
    logic        il;
    logic        sr;
    logic        huge;
    logic [7:0]  tlen;
    logic [7:0]  idlen;
    logic [31:0] plen;
    base = stim_q.size();
    nrec = (single && $urandom_range(0, 3) != 0) ? 1 : $urandom_range(1, 3);
    for (int r = 0; r < nrec; r++) begin
      nchunk = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
      tnf = 3'($urandom_range(0, 7));
      if (tnf == TNF_SAME) tnf = 3'd1;
      for (int c = 0; c < nchunk; c++) begin
        first = (c == 0);
        last  = (c == nchunk - 1);
        lead  = (r == 0) && first;
        il    = first && ($urandom_range(0, 1) == 1);
        sr    = ($urandom_range(0, 1) == 1);
        tlen  = '0;
        idlen = '0;
        plen  = '0;
        // Content rules of the TNF are mostly kept, sometimes broken.
        if (first && ((tnf != TNF_VOID && tnf != TNF_OPAQUE && tnf != TNF_RSVD) ||
                      $urandom_range(0, 3) == 0))
          tlen = 8'($urandom_range(0, 3));
        if (il && (tnf != TNF_VOID || $urandom_range(0, 3) == 0))
          idlen = 8'($urandom_range(0, 3));
        if (tnf != TNF_VOID || $urandom_range(0, 3) == 0)
          plen = 32'($urandom_range(0, 6));
        // A long-form length with a random value; its body is never sent.
        huge = ($urandom_range(0, 15) == 0);
        if (huge) begin
          sr   = 1'b0;
          plen = $urandom;
        end
        queue_record(lead, (r == nrec - 1) && last, !last, sr, il,
                     first ? tnf : TNF_SAME, tlen, idlen, plen,
                     lead && ($urandom_range(0, 7) != 0), !huge);
      end
    end
    // Now and then flip one bit anywhere in the message, the start flag included.
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(base, stim_q.size() - 1);
      stim_q[k] = stim_q[k] ^ (9'd1 << $urandom_range(0, 8));
    end
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0);
  endtask

  // Send every queued byte with a random gap before each one.
  task automatic send_items();
    logic [8:0] it;
    int         gap;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      if ($urandom_range(0, 47) == 0) src_calm = !src_calm;
      gap = src_calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      byte_ch.valid         <= 1'b1;
      byte_ch.data_byte     <= it[7:0];
      byte_ch.message_start <= it[8];
      @(posedge clk);
      while (!byte_ch.ready) @(posedge clk);
    end
  endtask

  // Wait until every predicted tag has come back, then let the pipeline settle.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (tags_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic single, input logic [31:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SINGLE_RECORD;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, single};
    @(posedge clk);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int          made;
    int          ph;
    logic        single;
    logic [31:0] limit;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= '0;
    byte_ch.message_start <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed bytes under the reset register values.
    // Short record with a type and a payload, then a byte after its end.
    queue_byte(8'hD1, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    // Empty record that ends on its last header byte.
    queue_byte(8'hD0, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    // Missing MB, then a byte that is only passed through.
    queue_byte(8'h11, 1'b1);
    queue_byte(8'h55, 1'b0);
    // Two-chunk record: type, id and payload in the first chunk, payload in the second.
    queue_byte(8'hBA, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h54, 1'b0);
    queue_byte(8'hA5, 1'b0);
    queue_byte(8'h7E, 1'b0);
    queue_byte(8'h56, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h81, 1'b0);
    queue_byte(8'h18, 1'b0);
    // Long-form payload length at its maximum is too large.
    queue_byte(8'hC1, 1'b1);
    queue_byte(8'h00, 1'b0);
    repeat (4) queue_byte(8'hFF, 1'b0);
    send_items();
    drain();

    // Random messages under a rotating set of register values.
    made = 0;
    ph   = 0;
    while (made < RANDOM_ITEMS) begin
      case (ph % 8)
        0: begin single = 1'b0; limit = MAX_PAYLOAD_RESET; end
        1: begin single = 1'b1; limit = MAX_PAYLOAD_RESET; end
        2: begin single = 1'b0; limit = '0; end
        3: begin single = 1'b1; limit = '0; end
        4: begin single = 1'b0; limit = '1; end
        5: begin single = 1'b0; limit = 32'($urandom_range(0, 12)); end
        6: begin single = 1'b1; limit = 32'($urandom_range(0, 12)); end
        default: begin single = 1'b0; limit = $urandom; end
      endcase
      set_config(single, limit);
      while (stim_q.size() < PHASE_ITEMS) queue_message(single);
      made = made + stim_q.size();
      send_items();
      drain();
      ph++;
    end

    if (bad_tags == 0 && tags_waiting == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
